### src/stn_pkg.sv
// ----------------------------------------------------------------------------
// Source text normaliser package
// Shared constants, item types and the character classifier.
// ----------------------------------------------------------------------------
package stn_pkg;

   localparam int KEYWORD_SLOTS = 64;
   localparam int KEYWORD_LEN   = 16;
   localparam int LINE_LIMIT    = 199;
   localparam int MAX_OUT       = 4;
   localparam int QUEUE_DEPTH   = 2;

   localparam int SLOT_W  = $clog2(KEYWORD_SLOTS);
   localparam int POS_W   = $clog2(KEYWORD_LEN);
   localparam int WLEN_W  = $clog2(KEYWORD_LEN + 1);
   localparam int COUNT_W = 7;

   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_KEYWORD = 8'h6D;
   localparam logic [7:0] CH_WORD    = 8'h77;
   localparam logic [7:0] CH_NUL     = 8'h00;

   typedef enum logic [1:0] {
      REQ_TEXT     = 2'd0,
      REQ_EOL      = 2'd1,
      REQ_EOF      = 2'd2,
      REQ_KW_WRITE = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      CLS_OTHER,
      CLS_ALNUM,
      CLS_SPACE,
      CLS_SLASH,
      CLS_NUL
   } char_class_type;

   typedef struct packed {
      req_kind_type   kind;
      logic [7:0]     char_code;
      logic [5:0]     slot;
      logic [3:0]     pos;
      char_class_type cls;
   } item_type;

   function automatic char_class_type classify(input logic [7:0] c);
      char_class_type r;
      if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
          (c >= 8'h61 && c <= 8'h7A)) begin
         r = CLS_ALNUM;
      end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
         r = CLS_SPACE;
      end else if (c == CH_SLASH) begin
         r = CLS_SLASH;
      end else if (c == CH_NUL) begin
         r = CLS_NUL;
      end else begin
         r = CLS_OTHER;
      end
      return r;
   endfunction

endpackage

### src/stn_if.sv
// ----------------------------------------------------------------------------
// Source text normaliser channel interfaces
// Request, response and register write channels with valid and ready.
// ----------------------------------------------------------------------------
interface stn_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] char_code;
   logic [5:0] keyword_slot;
   logic [3:0] keyword_pos;
   modport source (output valid, req_type, char_code, keyword_slot, keyword_pos,
                   input ready);
   modport sink (input valid, req_type, char_code, keyword_slot, keyword_pos,
                 output ready);
endinterface

interface stn_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       line_end;
   logic       last;
   modport source (output valid, out_char, line_end, last, input ready);
   modport sink (input valid, out_char, line_end, last, output ready);
endinterface

interface stn_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] keyword_count;
   modport source (output valid, keyword_count, input ready);
   modport sink (input valid, keyword_count, output ready);
endinterface

### src/stn_front.sv
// ----------------------------------------------------------------------------
// Source text normaliser front end
// Accepts requests, classifies the character and queues the item.
// ----------------------------------------------------------------------------
module stn_front (
   input  logic           clock,
   input  logic           reset,
   stn_req_if.sink        req_ch,
   output logic           item_valid,
   input  logic           item_ready,
   output stn_pkg::item_type item
);
   import stn_pkg::*;

   item_type   queue_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;
   item_type   new_item;

   assign req_ch.ready = (count_ff != 2'(QUEUE_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;
   assign item_valid   = (count_ff != 2'd0);
   assign pop          = item_valid && item_ready;
   assign item         = queue_ff[rd_ptr_ff];

   always_comb begin
      new_item.kind      = req_kind_type'(req_ch.req_type);
      new_item.char_code = req_ch.char_code;
      new_item.slot      = req_ch.keyword_slot;
      new_item.pos       = req_ch.keyword_pos;
      new_item.cls       = classify(req_ch.char_code);
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

### src/stn_back.sv
// ----------------------------------------------------------------------------
// Source text normaliser back end
// Sequences word, quote and line handling, searches the keyword table and
// delivers the results of each item through an output register.
// ----------------------------------------------------------------------------
module stn_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   output logic              item_ready,
   input  stn_pkg::item_type item,
   input  logic [6:0]        keyword_count,
   stn_rsp_if.source         rsp_ch
);
   import stn_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_CHAR, S_EOLF, S_SYM, S_SEARCH, S_FLUSHED, S_POST, S_CLOSE, S_DRAIN
   } state_type;

   typedef enum logic [1:0] {M_TEXT, M_NUL, M_SLASH, M_FLUSH} mode_type;

   typedef struct packed {
      logic [MAX_OUT-1:0][8:0] ent;
      logic [2:0]              n;
   } ebuf_type;

   state_type      state_ff, state_in, next_ff, next_in;
   req_kind_type   kind_ff, kind_in;
   logic [7:0]     char_ff, char_in, sym_ff, sym_in;
   char_class_type cls_ff, cls_in, sym_cls_ff, sym_cls_in;
   mode_type       mode_ff, mode_in;

   logic              slash_ff, slash_in, comment_ff, comment_in;
   logic [7:0]        wbuf_ff [KEYWORD_LEN];
   logic              wbuf_we;
   logic [WLEN_W-1:0] wlen_ff, wlen_in;
   logic              too_long_ff, too_long_in;
   logic [1:0]        quote_ff, quote_in;
   logic [7:0]        line_cnt_ff, line_cnt_in, prev_len_ff, prev_len_in;
   logic              prev_ex_ff, prev_ex_in, held_v_ff, held_v_in;
   logic [7:0]        held_ff, held_in, first_ff, first_in;

   ebuf_type          ebuf_ff, ebuf_in;
   logic [2:0]        idx_ff, idx_in;

   logic [KEYWORD_LEN-1:0][7:0] kw_mem [KEYWORD_SLOTS];
   logic [KEYWORD_LEN-1:0][7:0] kw_rd_ff;
   logic                        kw_we;
   logic [COUNT_W-1:0]          k_ff, k_in, n_lim;
   logic                        pend_ff, pend_in, hit_ff, hit_in, rd_en, row_match;

   logic       out_v_ff, out_v_in, out_end_ff, out_end_in, out_last_ff, out_last_in;
   logic [7:0] out_char_ff, out_char_in;

   logic       q_en, put_en;
   logic [7:0] q_char;

   function automatic ebuf_type push(input ebuf_type b, input logic [7:0] c,
                                     input logic e);
      ebuf_type r;
      r = b;
      if (b.n < 3'(MAX_OUT)) begin
         r.ent[b.n[1:0]] = {e, c};
         r.n             = b.n + 3'd1;
      end
      return r;
   endfunction

   assign item_ready = (state_ff == S_IDLE);
   assign kw_we      = (state_ff == S_IDLE) && item_valid && (item.kind == REQ_KW_WRITE);
   assign n_lim      = (keyword_count > 7'(KEYWORD_SLOTS)) ? 7'(KEYWORD_SLOTS) : keyword_count;
   assign rd_en      = (state_ff == S_SEARCH) && (k_ff < n_lim);
   assign wbuf_we    = (state_ff == S_SYM) && (mode_ff == M_TEXT) &&
                       (sym_cls_ff == CLS_ALNUM) && (wlen_ff < WLEN_W'(KEYWORD_LEN));

   always_comb begin
      row_match = 1'b1;
      for (int p = 0; p < KEYWORD_LEN; p++) begin
         if ((WLEN_W'(p) < wlen_ff) && (kw_rd_ff[p] != wbuf_ff[p])) begin
            row_match = 1'b0;
         end
      end
      if ((wlen_ff != WLEN_W'(KEYWORD_LEN)) && (kw_rd_ff[wlen_ff[POS_W-1:0]] != CH_NUL)) begin
         row_match = 1'b0;
      end
   end

   always_comb begin
      state_in    = state_ff;
      next_in     = next_ff;
      kind_in     = kind_ff;
      char_in     = char_ff;
      cls_in      = cls_ff;
      sym_in      = sym_ff;
      sym_cls_in  = sym_cls_ff;
      mode_in     = mode_ff;
      slash_in    = slash_ff;
      comment_in  = comment_ff;
      wlen_in     = wlen_ff;
      too_long_in = too_long_ff;
      quote_in    = quote_ff;
      line_cnt_in = line_cnt_ff;
      prev_len_in = prev_len_ff;
      prev_ex_in  = prev_ex_ff;
      held_v_in   = held_v_ff;
      held_in     = held_ff;
      first_in    = first_ff;
      ebuf_in     = ebuf_ff;
      idx_in      = idx_ff;
      k_in        = k_ff;
      pend_in     = 1'b0;
      hit_in      = hit_ff;
      q_en        = 1'b0;
      q_char      = sym_ff;
      put_en      = 1'b0;
      out_v_in    = out_v_ff && !rsp_ch.ready;
      out_char_in = out_char_ff;
      out_end_in  = out_end_ff;
      out_last_in = out_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               kind_in   = item.kind;
               char_in   = item.char_code;
               cls_in    = item.cls;
               ebuf_in.n = 3'd0;
               idx_in    = 3'd0;
               sym_in    = CH_SLASH;
               sym_cls_in = CLS_OTHER;
               mode_in   = M_TEXT;
               case (item.kind)
                  REQ_TEXT: begin
                     if (comment_ff) begin
                        state_in = S_DRAIN;
                     end else if (slash_ff) begin
                        slash_in = 1'b0;
                        if (item.cls == CLS_SLASH) begin
                           comment_in = 1'b1;
                           state_in   = S_DRAIN;
                        end else begin
                           next_in  = S_CHAR;
                           state_in = S_SYM;
                        end
                     end else begin
                        state_in = S_CHAR;
                     end
                  end
                  REQ_EOL, REQ_EOF: begin
                     if (slash_ff) begin
                        slash_in = 1'b0;
                        next_in  = S_EOLF;
                        state_in = S_SYM;
                     end else begin
                        state_in = S_EOLF;
                     end
                  end
                  default: begin
                     state_in = S_DRAIN;
                  end
               endcase
            end
         end
         S_CHAR: begin
            sym_in     = char_ff;
            sym_cls_in = cls_ff;
            mode_in    = (cls_ff == CLS_NUL) ? M_NUL :
                         (cls_ff == CLS_SLASH) ? M_SLASH : M_TEXT;
            next_in    = S_DRAIN;
            state_in   = S_SYM;
         end
         S_EOLF: begin
            mode_in  = M_FLUSH;
            next_in  = S_CLOSE;
            state_in = S_SYM;
         end
         S_SYM: begin
            if ((mode_ff == M_TEXT) && (sym_cls_ff == CLS_ALNUM)) begin
               if (wbuf_we) begin
                  wlen_in = wlen_ff + WLEN_W'(1);
               end else begin
                  too_long_in = 1'b1;
               end
               state_in = next_ff;
            end else if (wlen_ff != '0) begin
               hit_in = 1'b0;
               k_in   = '0;
               state_in = too_long_ff ? S_FLUSHED : S_SEARCH;
            end else begin
               state_in = S_POST;
            end
         end
         S_SEARCH: begin
            if (rd_en) begin
               k_in    = k_ff + COUNT_W'(1);
               pend_in = 1'b1;
            end
            if (pend_ff && row_match) begin
               hit_in = 1'b1;
            end
            if (!rd_en && !pend_ff) begin
               state_in = S_FLUSHED;
            end
         end
         S_FLUSHED: begin
            q_en        = 1'b1;
            q_char      = hit_ff ? CH_KEYWORD : CH_WORD;
            wlen_in     = '0;
            too_long_in = 1'b0;
            state_in    = S_POST;
         end
         S_POST: begin
            case (mode_ff)
               M_TEXT:  q_en = (sym_cls_ff != CLS_SPACE);
               M_NUL:   comment_in = 1'b1;
               M_SLASH: slash_in = 1'b1;
               default: q_en = 1'b0;
            endcase
            state_in = next_ff;
         end
         S_CLOSE: begin
            if (line_cnt_ff == 8'd1) begin
               if (prev_ex_ff && (prev_len_ff < 8'(LINE_LIMIT))) begin
                  ebuf_in     = push(ebuf_in, held_ff, 1'b0);
                  held_in     = first_ff;
                  prev_len_in = prev_len_ff + 8'd1;
               end else begin
                  if (held_v_ff) begin
                     ebuf_in = push(ebuf_in, held_ff, 1'b1);
                  end
                  held_in     = first_ff;
                  held_v_in   = 1'b1;
                  prev_ex_in  = 1'b1;
                  prev_len_in = 8'd1;
               end
            end else if (line_cnt_ff >= 8'd2) begin
               prev_ex_in  = 1'b1;
               prev_len_in = line_cnt_ff;
            end
            line_cnt_in = 8'd0;
            comment_in  = 1'b0;
            quote_in    = 2'd0;
            if (kind_ff == REQ_EOF) begin
               if (held_v_in) begin
                  ebuf_in = push(ebuf_in, held_in, 1'b1);
               end
               slash_in    = 1'b0;
               wlen_in     = '0;
               too_long_in = 1'b0;
               prev_len_in = 8'd0;
               prev_ex_in  = 1'b0;
               held_in     = 8'd0;
               held_v_in   = 1'b0;
               first_in    = 8'd0;
            end
            state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (idx_ff == ebuf_ff.n) begin
               state_in = S_IDLE;
            end else if (!out_v_ff || rsp_ch.ready) begin
               out_v_in    = 1'b1;
               out_char_in = ebuf_ff.ent[idx_ff[1:0]][7:0];
               out_end_in  = ebuf_ff.ent[idx_ff[1:0]][8];
               out_last_in = (idx_ff + 3'd1 == ebuf_ff.n);
               idx_in      = idx_ff + 3'd1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (q_en) begin
         if (quote_ff != 2'd0) begin
            if (((quote_ff == 2'd1) && (q_char == CH_DQUOTE)) ||
                ((quote_ff == 2'd2) && (q_char == CH_SQUOTE))) begin
               quote_in = 2'd0;
               put_en   = 1'b1;
            end
         end else begin
            if (q_char == CH_DQUOTE) begin
               quote_in = 2'd1;
            end else if (q_char == CH_SQUOTE) begin
               quote_in = 2'd2;
            end
            put_en = 1'b1;
         end
      end

      if (put_en) begin
         if (line_cnt_ff == 8'd0) begin
            first_in    = q_char;
            line_cnt_in = 8'd1;
         end else if (line_cnt_ff == 8'd1) begin
            if (held_v_ff) begin
               ebuf_in = push(ebuf_in, held_ff, 1'b1);
            end
            ebuf_in     = push(ebuf_in, first_ff, 1'b0);
            held_in     = q_char;
            held_v_in   = 1'b1;
            prev_ex_in  = 1'b0;
            line_cnt_in = 8'd2;
         end else begin
            ebuf_in = push(ebuf_in, held_ff, 1'b0);
            held_in = q_char;
            if (line_cnt_ff != 8'd255) begin
               line_cnt_in = line_cnt_ff + 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         next_ff     <= S_DRAIN;
         kind_ff     <= REQ_TEXT;
         mode_ff     <= M_TEXT;
         slash_ff    <= 1'b0;
         comment_ff  <= 1'b0;
         wlen_ff     <= '0;
         too_long_ff <= 1'b0;
         quote_ff    <= 2'd0;
         line_cnt_ff <= 8'd0;
         prev_len_ff <= 8'd0;
         prev_ex_ff  <= 1'b0;
         held_v_ff   <= 1'b0;
         held_ff     <= 8'd0;
         first_ff    <= 8'd0;
         ebuf_ff.n   <= 3'd0;
         idx_ff      <= 3'd0;
         k_ff        <= '0;
         pend_ff     <= 1'b0;
         hit_ff      <= 1'b0;
         out_v_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         next_ff     <= next_in;
         kind_ff     <= kind_in;
         mode_ff     <= mode_in;
         slash_ff    <= slash_in;
         comment_ff  <= comment_in;
         wlen_ff     <= wlen_in;
         too_long_ff <= too_long_in;
         quote_ff    <= quote_in;
         line_cnt_ff <= line_cnt_in;
         prev_len_ff <= prev_len_in;
         prev_ex_ff  <= prev_ex_in;
         held_v_ff   <= held_v_in;
         held_ff     <= held_in;
         first_ff    <= first_in;
         ebuf_ff     <= ebuf_in;
         idx_ff      <= idx_in;
         k_ff        <= k_in;
         pend_ff     <= pend_in;
         hit_ff      <= hit_in;
         out_v_ff    <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      cls_ff      <= cls_in;
      sym_ff      <= sym_in;
      sym_cls_ff  <= sym_cls_in;
      out_char_ff <= out_char_in;
      out_end_ff  <= out_end_in;
      out_last_ff <= out_last_in;
      if (wbuf_we) begin
         wbuf_ff[wlen_ff[POS_W-1:0]] <= sym_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (kw_we) begin
         kw_mem[item.slot][item.pos] <= item.char_code;
      end
      kw_rd_ff <= kw_mem[k_ff[SLOT_W-1:0]];
   end

   assign rsp_ch.valid    = out_v_ff;
   assign rsp_ch.out_char = out_char_ff;
   assign rsp_ch.line_end = out_end_ff;
   assign rsp_ch.last     = out_last_ff;

   a_word_len: assert property (@(posedge clock) disable iff (reset)
      wlen_ff <= WLEN_W'(KEYWORD_LEN)) else $error("word length overrun");

   a_quote: assert property (@(posedge clock) disable iff (reset)
      quote_ff != 2'd3) else $error("bad quote kind");

   a_search: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (wlen_ff != '0) && !too_long_ff)
      else $error("search without a matchable word");

   a_held: assert property (@(posedge clock) disable iff (reset)
      (line_cnt_ff >= 8'd2) |-> held_v_ff) else $error("open line without held character");

endmodule

### src/source_text_normalizer.sv
// ----------------------------------------------------------------------------
// Source text normaliser
// Turns a character stream into normalised tokens: comments cut, words mapped
// to keyword or word marks, quotes collapsed, short lines merged.
//
//   Channel  Dir  Payload
//   req_ch   in   req_type, char_code, keyword_slot, keyword_pos
//   rsp_ch   out  out_char, line_end, last
//   csr_ch   in   keyword_count
//
// An item passes through sequencing states, emits its results and returns to idle.
// A word end adds a walk over min(keyword_count, 64) table rows and a mark;
// a word longer than a table row skips the walk.
// Results leave through an output register, one per cycle when not stalled;
// a stalled response holds the back end. A two-entry queue takes requests
// while the back end works. Reset is synchronous; the keyword table is
// undefined until written.
// ----------------------------------------------------------------------------
module source_text_normalizer (
   input  logic      clock,
   input  logic      reset,
   stn_req_if.sink   req_ch,
   stn_rsp_if.source rsp_ch,
   stn_csr_if.sink   csr_ch
);
   import stn_pkg::*;

   logic [COUNT_W-1:0] kw_count_ff;
   logic               item_valid, item_ready;
   item_type           item;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kw_count_ff <= '0;
      end else if (csr_ch.valid) begin
         kw_count_ff <= csr_ch.keyword_count;
      end
   end

   stn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   stn_back u_back (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (item_valid),
      .item_ready    (item_ready),
      .item          (item),
      .keyword_count (kw_count_ff),
      .rsp_ch        (rsp_ch)
   );

endmodule

### tb/source_text_normalizer_test.sv
// ----------------------------------------------------------------------------
// Source text normaliser testbench
// Drives character, line end, file end and keyword table requests through the
// request channel, predicts the normalised character stream and checks every
// response transfer in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module source_text_normalizer_test;
   import stn_pkg::*;

   typedef struct {
      logic [7:0] out_char;
      logic       line_end;
      logic       last;
   } token_type;

   logic clock;
   logic reset;

   stn_req_if req_ch ();
   stn_rsp_if rsp_ch ();
   stn_csr_if csr_ch ();

   source_text_normalizer u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   // Predictor state.
   logic [6:0] kw_count;
   logic [7:0] kw_table [KEYWORD_SLOTS * KEYWORD_LEN];
   logic [7:0] word_buf [KEYWORD_LEN];
   int         word_len;
   bit         word_long;
   bit         slash_wait;
   bit         comment_on;
   int         quote_mode;
   int         line_count;
   int         prev_len;
   bit         prev_kept;
   logic [7:0] held_chr;
   bit         held_on;
   logic [7:0] first_chr;

   token_type  expected_tokens[$];
   token_type  step_tokens[$];
   int         error_count;
   int         idle_cycles;
   bit         rsp_stall_on;
   bit         req_gap_on;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("mismatch: %s", what);
   endtask

   function automatic void put_token(input logic [7:0] c, input bit e);
      token_type t;
      t.out_char = c;
      t.line_end = e;
      t.last     = 1'b0;
      if (step_tokens.size() < MAX_OUT) step_tokens.push_back(t);
   endfunction

   function automatic void line_put(input logic [7:0] x);
      if (line_count == 0) begin
         first_chr = x;
         line_count = 1;
      end else if (line_count == 1) begin
         if (held_on) put_token(held_chr, 1'b1);
         put_token(first_chr, 1'b0);
         held_chr = x;
         held_on = 1'b1;
         prev_kept = 1'b0;
         line_count = 2;
      end else begin
         put_token(held_chr, 1'b0);
         held_chr = x;
         if (line_count < 255) line_count++;
      end
   endfunction

   function automatic void line_close();
      if (line_count == 1) begin
         if (prev_kept && prev_len < LINE_LIMIT) begin
            put_token(held_chr, 1'b0);
            held_chr = first_chr;
            prev_len++;
         end else begin
            if (held_on) put_token(held_chr, 1'b1);
            held_chr = first_chr;
            held_on = 1'b1;
            prev_kept = 1'b1;
            prev_len = 1;
         end
      end else if (line_count >= 2) begin
         prev_kept = 1'b1;
         prev_len = line_count;
      end
      line_count = 0;
   endfunction

   function automatic void quote_filter(input logic [7:0] e);
      if (quote_mode != 0) begin
         if ((quote_mode == 1 && e == CH_DQUOTE) || (quote_mode == 2 && e == CH_SQUOTE)) begin
            quote_mode = 0;
            line_put(e);
         end
         return;
      end
      if (e == CH_DQUOTE) quote_mode = 1;
      else if (e == CH_SQUOTE) quote_mode = 2;
      line_put(e);
   endfunction

   function automatic bit word_matches();
      int n;
      int len;
      bit same;
      if (word_long || word_len == 0) return 1'b0;
      n = (kw_count > KEYWORD_SLOTS) ? KEYWORD_SLOTS : kw_count;
      for (int k = 0; k < n; k++) begin
         len = KEYWORD_LEN;
         for (int p = KEYWORD_LEN - 1; p >= 0; p--)
            if (kw_table[k * KEYWORD_LEN + p] == 8'h00) len = p;
         if (len == word_len) begin
            same = 1'b1;
            for (int p = 0; p < len; p++)
               if (kw_table[k * KEYWORD_LEN + p] != word_buf[p]) same = 1'b0;
            if (same) return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void word_flush();
      if (word_len == 0) return;
      quote_filter(word_matches() ? CH_KEYWORD : CH_WORD);
      word_len = 0;
      word_long = 1'b0;
   endfunction

   function automatic void word_feed(input logic [7:0] d);
      char_class_type cls;
      cls = (d >= 8'h30 && d <= 8'h39) || (d >= 8'h41 && d <= 8'h5A) ||
            (d >= 8'h61 && d <= 8'h7A) ? CLS_ALNUM :
            (d == 8'h20 || (d >= 8'h09 && d <= 8'h0D)) ? CLS_SPACE : CLS_OTHER;
      if (cls == CLS_ALNUM) begin
         if (word_len < KEYWORD_LEN) word_buf[word_len++] = d;
         else word_long = 1'b1;
         return;
      end
      word_flush();
      if (cls != CLS_SPACE) quote_filter(d);
   endfunction

   function automatic void end_line();
      if (slash_wait) begin
         slash_wait = 1'b0;
         word_feed(CH_SLASH);
      end
      word_flush();
      line_close();
      comment_on = 1'b0;
      quote_mode = 0;
   endfunction

   function automatic void clear_stream();
      slash_wait = 1'b0;
      comment_on = 1'b0;
      word_len = 0;
      word_long = 1'b0;
      quote_mode = 0;
      line_count = 0;
      prev_len = 0;
      prev_kept = 1'b0;
      held_chr = 8'h00;
      held_on = 1'b0;
      first_chr = 8'h00;
   endfunction

   function automatic void predict_normalised(input req_kind_type kind, input logic [7:0] c,
                                              input logic [5:0] slot, input logic [3:0] pos);
      step_tokens.delete();
      case (kind)
         REQ_TEXT: begin
            if (!comment_on) begin
               if (slash_wait) begin
                  slash_wait = 1'b0;
                  if (c == CH_SLASH) comment_on = 1'b1;
                  else word_feed(CH_SLASH);
               end
               if (!comment_on) begin
                  if (c == CH_NUL) begin
                     word_flush();
                     comment_on = 1'b1;
                  end else if (c == CH_SLASH) begin
                     word_flush();
                     slash_wait = 1'b1;
                  end else begin
                     word_feed(c);
                  end
               end
            end
         end
         REQ_EOL: end_line();
         REQ_EOF: begin
            end_line();
            if (held_on) put_token(held_chr, 1'b1);
            clear_stream();
         end
         default: begin
            if (slot < KEYWORD_SLOTS && pos < KEYWORD_LEN) begin
               kw_table[slot * KEYWORD_LEN + pos] = c;
            end
         end
      endcase
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
   endfunction

   // The request stays valid after a transfer until the next request or idle
   // period replaces it at the following falling edge.
   task automatic send_item(input req_kind_type kind, input logic [7:0] c,
                            input logic [5:0] slot = 6'd0, input logic [3:0] pos = 4'd0);
      int gap;
      if (req_gap_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.req_type <= kind;
      req_ch.char_code <= c;
      req_ch.keyword_slot <= slot;
      req_ch.keyword_pos <= pos;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_normalised(kind, c, slot, pos);
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(REQ_TEXT, s[i]);
   endtask

   task automatic load_keyword(input logic [5:0] slot, input string s);
      for (int i = 0; i < s.len() && i < KEYWORD_LEN; i++)
         send_item(REQ_KW_WRITE, s[i], slot, 4'(i));
      if (s.len() < KEYWORD_LEN) send_item(REQ_KW_WRITE, 8'h00, slot, 4'(s.len()));
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_tokens.size() != 0) @(negedge clock);
      repeat (KEYWORD_SLOTS + 40) @(negedge clock);
   endtask

   task automatic write_keyword_count(input logic [6:0] value);
      drain();
      csr_ch.valid <= 1'b1;
      csr_ch.keyword_count <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      kw_count = value;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic test_directed_cases();
      load_keyword(6'd0, "if");
      load_keyword(6'd1, "while");
      load_keyword(6'd2, "abcdefghijklmnop");
      send_item(REQ_KW_WRITE, 8'hFF, 6'd63, 4'd15);
      send_item(REQ_KW_WRITE, 8'h00, 6'd63, 4'd0);
      write_keyword_count(7'd3);
      send_text("if (x) \"a//b\" 'q");
      send_item(REQ_EOL, 8'h00);
      send_text("abcdefghijklmnopq // tail");
      send_item(REQ_EOL, 8'h00);
      send_text("}");
      send_item(REQ_EOL, 8'h00);
      send_item(REQ_EOL, 8'h00);
      send_text("a/");
      send_item(REQ_EOL, 8'h00);
      send_item(REQ_TEXT, 8'h00);
      send_text("zz");
      send_item(REQ_TEXT, 8'hFF);
      send_item(REQ_EOF, 8'h00);
      send_item(REQ_EOF, 8'h00);
   endtask

   task automatic test_count_settings();
      write_keyword_count(7'd0);
      send_text("if while x;");
      send_item(REQ_EOF, 8'h00);
      write_keyword_count(7'd1);
      send_text("while if");
      send_item(REQ_EOF, 8'h00);
      write_keyword_count(7'd3);
   endtask

   task automatic test_merge_limit();
      // A short line, then single characters that merge onto it.
      for (int i = 0; i < 10; i++) send_item(REQ_TEXT, (i % 2) ? 8'h3B : 8'h2B);
      send_item(REQ_EOL, 8'h00);
      for (int i = 0; i < 4; i++) begin
         send_item(REQ_TEXT, 8'h7B);
         send_item(REQ_EOL, 8'h00);
      end
      send_item(REQ_EOF, 8'h00);
   endtask

   function automatic logic [7:0] pick_char();
      int r;
      string pool;
      pool = "abwhileif09 \t/\"';{}()=+";
      r = $urandom_range(0, 9);
      if (r == 0) return 8'($urandom_range(0, 255));
      return pool[$urandom_range(0, pool.len() - 1)];
   endfunction

   // Random table writes go to the fully loaded slot two only.
   task automatic test_random_text(input int items);
      int kind;
      for (int i = 0; i < items; i++) begin
         kind = $urandom_range(0, 19);
         if (kind < 15) begin
            send_item(REQ_TEXT, pick_char());
         end else if (kind < 18) begin
            send_item(REQ_EOL, 8'h00);
         end else if (kind < 19) begin
            send_item(REQ_EOF, 8'h00);
         end else begin
            send_item(REQ_KW_WRITE, 8'($urandom_range(0, 255)), 6'd2,
                      4'($urandom_range(0, 15)));
         end
      end
      send_item(REQ_EOF, 8'h00);
   endtask

   task automatic test_pause_until_empty();
      send_text("x=y;");
      send_item(REQ_EOL, 8'h00);
      drain();
      send_text("z;");
      send_item(REQ_EOF, 8'h00);
   endtask

   // Response checker.
   always @(posedge clock) begin
      token_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_tokens.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer char %h", rsp_ch.out_char));
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_ch.out_char !== want.out_char)
               report_mismatch($sformatf("out_char %h, want %h", rsp_ch.out_char,
                                         want.out_char));
            if (rsp_ch.line_end !== want.line_end)
               report_mismatch($sformatf("line_end %b, want %b", rsp_ch.line_end,
                                         want.line_end));
            if (rsp_ch.last !== want.last)
               report_mismatch($sformatf("last %b, want %b", rsp_ch.last, want.last));
         end
      end
   end

   // Receiver stalls in random bursts.
   initial begin
      int burst;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_stall_on && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 5);
            rsp_ch.ready <= 1'b0;
            repeat (burst) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (req_ch.valid && req_ch.ready || rsp_ch.valid && rsp_ch.ready ||
          csr_ch.valid && csr_ch.ready) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 20000) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      error_count = 0;
      idle_cycles = 0;
      rsp_stall_on = 1'b1;
      req_gap_on = 1'b1;
      kw_count = 7'd0;
      foreach (kw_table[i]) kw_table[i] = 8'h00;
      foreach (word_buf[i]) word_buf[i] = 8'h00;
      clear_stream();
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.req_type = REQ_TEXT;
      req_ch.char_code = 8'h00;
      req_ch.keyword_slot = 6'd0;
      req_ch.keyword_pos = 4'd0;
      csr_ch.valid = 1'b0;
      csr_ch.keyword_count = 7'd0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_cases();
      test_count_settings();
      test_merge_limit();
      test_pause_until_empty();
      test_random_text(25);
      write_keyword_count(7'd2);
      rsp_stall_on = 1'b0;
      req_gap_on = 1'b0;
      test_random_text(12);
      drain();
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
